[design/grid_bbox_decode_filter_assert.svh]
// assertion macros for the grid box decoder
`ifndef GRID_BBOX_DECODE_FILTER_ASSERT_SVH
`define GRID_BBOX_DECODE_FILTER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define GBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("grid box decoder assertion failed");
// next-cycle implication
`define GBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("grid box decoder assertion failed");
`else
`define GBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[design/gbd_pkg.sv]
// shared types, constants and helpers of the grid box decoder
package gbd_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int CLS_W       = 2;
    localparam int GRID_W      = 8;
    localparam int SIZE_W      = 13;
    localparam int CONF_W      = 16;
    localparam int OFS_W       = 16;
    localparam int COORD_W     = 16;
    localparam int DIM_W       = 17;
    localparam int PROD_W      = GRID_W + SIZE_W;
    localparam int CX_W        = PROD_W + 4;
    localparam int RAW_W       = CX_W + 1;
    localparam int SCL_W       = 22;
    localparam int D_W         = SCL_W - 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam int BOX_NORM    = 35;
    localparam int MAX_SIZE    = 4096;
    localparam logic [COORD_W-1:0] MAX_LIMIT = COORD_W'((MAX_SIZE - 1) * 16);

    localparam logic [SIZE_W-1:0] RST_WIDTH  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] RST_HEIGHT = SIZE_W'(480);
    localparam logic [SIZE_W-1:0] RST_STRIDE = SIZE_W'(16);
    localparam logic [CONF_W-1:0] RST_THR    = CONF_W'(26214);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_STRIDE_X     = 3'd2,
        REG_STRIDE_Y     = 3'd3,
        REG_THR0         = 3'd4,
        REG_THR1         = 3'd5,
        REG_THR2         = 3'd6,
        REG_THR3         = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [SIZE_W-1:0]                   image_width;
        logic [SIZE_W-1:0]                   image_height;
        logic [SIZE_W-1:0]                   pitch_x;
        logic [SIZE_W-1:0]                   pitch_y;
        logic [NUM_CLASSES-1:0][CONF_W-1:0]  thr;
    } t_cfg;

    // kept cell after the front: reference point and scaled offsets
    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [CONF_W-1:0] conf;
        logic [CX_W-1:0]   cx;
        logic [CX_W-1:0]   cy;
        logic [D_W-1:0]    dx1;
        logic [D_W-1:0]    dy1;
        logic [D_W-1:0]    dx2;
        logic [D_W-1:0]    dy2;
    } t_cell;

    // floor((35*o + 128) / 256), an arithmetic shift of the rounded product
    function automatic logic [D_W-1:0] scale_offset(input logic [OFS_W-1:0] o);
        logic signed [SCL_W-1:0] t;
        t = SCL_W'($signed(o)) * SCL_W'(BOX_NORM) + SCL_W'(128);
        return t[SCL_W-1:8];
    endfunction

    // (size-1)*16 with size saturated to the largest image, zero for size zero
    function automatic logic [COORD_W-1:0] clip_limit(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] m1;
        m1 = size - 1'b1;
        if (size == '0) begin
            return '0;
        end else if (size > SIZE_W'(MAX_SIZE)) begin
            return MAX_LIMIT;
        end
        return {m1[COORD_W-5:0], 4'b0000};
    endfunction

    function automatic logic [COORD_W-1:0] clip(input logic [RAW_W-1:0] raw,
                                                input logic [COORD_W-1:0] lim);
        if (raw[RAW_W-1]) begin
            return '0;
        end else if (raw[RAW_W-2:0] > (RAW_W-1)'(lim)) begin
            return lim;
        end
        return raw[COORD_W-1:0];
    endfunction

endpackage

[design/gbd_cfg.sv]
// configuration registers of the grid box decoder
module gbd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output gbd_pkg::t_cfg                 o_cfg
);
    import gbd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= RST_WIDTH;
            r_cfg.image_height <= RST_HEIGHT;
            r_cfg.pitch_x      <= RST_STRIDE;
            r_cfg.pitch_y      <= RST_STRIDE;
            r_cfg.thr          <= {NUM_CLASSES{RST_THR}};
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data[SIZE_W-1:0];
                REG_STRIDE_X:     r_cfg.pitch_x      <= i_cfg_data[SIZE_W-1:0];
                REG_STRIDE_Y:     r_cfg.pitch_y      <= i_cfg_data[SIZE_W-1:0];
                REG_THR0:         r_cfg.thr[0]       <= i_cfg_data[CONF_W-1:0];
                REG_THR1:         r_cfg.thr[1]       <= i_cfg_data[CONF_W-1:0];
                REG_THR2:         r_cfg.thr[2]       <= i_cfg_data[CONF_W-1:0];
                REG_THR3:         r_cfg.thr[3]       <= i_cfg_data[CONF_W-1:0];
                default:          ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/gbd_front.sv]
// front end: threshold test, reference point and offset scaling
module gbd_front (
    input  logic                        i_valid,
    input  logic                        i_space,
    input  logic [gbd_pkg::CLS_W-1:0]   i_class_id,
    input  logic [gbd_pkg::GRID_W-1:0]  i_cell_col,
    input  logic [gbd_pkg::GRID_W-1:0]  i_cell_row,
    input  logic [gbd_pkg::CONF_W-1:0]  i_confidence,
    input  logic [gbd_pkg::OFS_W-1:0]   i_offset_x1,
    input  logic [gbd_pkg::OFS_W-1:0]   i_offset_y1,
    input  logic [gbd_pkg::OFS_W-1:0]   i_offset_x2,
    input  logic [gbd_pkg::OFS_W-1:0]   i_offset_y2,
    input  gbd_pkg::t_cfg               i_cfg,
    output logic                        o_ready,
    output logic                        o_push,
    output gbd_pkg::t_cell              o_cell
);
    import gbd_pkg::*;

    logic              keep;
    logic [PROD_W-1:0] prod_x;
    logic [PROD_W-1:0] prod_y;

    // class and grid fields are narrow enough that every code is in range
    assign keep   = i_confidence >= i_cfg.thr[i_class_id];
    assign prod_x = PROD_W'(i_cell_col) * PROD_W'(i_cfg.pitch_x);
    assign prod_y = PROD_W'(i_cell_row) * PROD_W'(i_cfg.pitch_y);

    assign o_ready = i_space;
    assign o_push  = i_valid && i_space && keep;

    always_comb begin
        o_cell.cls  = i_class_id;
        o_cell.conf = i_confidence;
        o_cell.cx   = {prod_x, 4'b1000};
        o_cell.cy   = {prod_y, 4'b1000};
        o_cell.dx1  = scale_offset(i_offset_x1);
        o_cell.dy1  = scale_offset(i_offset_y1);
        o_cell.dx2  = scale_offset(i_offset_x2);
        o_cell.dy2  = scale_offset(i_offset_y2);
    end

endmodule

[design/gbd_queue.sv]
// short queue between front and back
module gbd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gbd_pkg::t_cell i_cell,
    input  logic           i_pop,
    output logic           o_space,
    output logic           o_valid,
    output gbd_pkg::t_cell o_cell
);
    import gbd_pkg::*;

    t_cell              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QCNT_W-1:0]  n_count;

    assign o_space = r_count != QCNT_W'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_cell  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cell;
        end
    end

    // depth is a power of two, pointers wrap on their own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

[design/gbd_back.sv]
// back end: edge decode, clipping, empty box test and output register
`include "grid_bbox_decode_filter_assert.svh"
module gbd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gbd_pkg::t_cfg               i_cfg,
    input  logic                        i_q_valid,
    input  gbd_pkg::t_cell              i_q_cell,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [gbd_pkg::CLS_W-1:0]   o_det_class,
    output logic [gbd_pkg::CONF_W-1:0]  o_det_confidence,
    output logic [gbd_pkg::COORD_W-1:0] o_box_left,
    output logic [gbd_pkg::COORD_W-1:0] o_box_top,
    output logic [gbd_pkg::DIM_W-1:0]   o_box_width,
    output logic [gbd_pkg::DIM_W-1:0]   o_box_height
);
    import gbd_pkg::*;

    logic [COORD_W-1:0] lim_x;
    logic [COORD_W-1:0] lim_y;
    logic [RAW_W-1:0]   raw_l, raw_t, raw_r, raw_b;
    logic               a_adv;
    logic               b_take;
    logic               box_ok;

    // clip stage
    logic               r_a_valid;
    logic [CLS_W-1:0]   r_a_cls;
    logic [CONF_W-1:0]  r_a_conf;
    logic [COORD_W-1:0] r_a_left, r_a_top, r_a_right, r_a_bottom;

    // output register
    logic               r_o_valid;
    logic [CLS_W-1:0]   r_o_cls;
    logic [CONF_W-1:0]  r_o_conf;
    logic [COORD_W-1:0] r_o_left, r_o_top;
    logic [DIM_W-1:0]   r_o_width, r_o_height;

    assign lim_x = clip_limit(i_cfg.image_width);
    assign lim_y = clip_limit(i_cfg.image_height);

    assign raw_l = {1'b0, i_q_cell.cx} - {{(RAW_W-D_W){i_q_cell.dx1[D_W-1]}}, i_q_cell.dx1};
    assign raw_t = {1'b0, i_q_cell.cy} - {{(RAW_W-D_W){i_q_cell.dy1[D_W-1]}}, i_q_cell.dy1};
    assign raw_r = {1'b0, i_q_cell.cx} + {{(RAW_W-D_W){i_q_cell.dx2[D_W-1]}}, i_q_cell.dx2};
    assign raw_b = {1'b0, i_q_cell.cy} + {{(RAW_W-D_W){i_q_cell.dy2[D_W-1]}}, i_q_cell.dy2};

    assign b_take  = !r_o_valid || i_ready;
    assign a_adv   = !r_a_valid || b_take;
    assign o_q_pop = i_q_valid && a_adv;
    assign box_ok  = (r_a_right > r_a_left) && (r_a_bottom > r_a_top);

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_cls    <= i_q_cell.cls;
            r_a_conf   <= i_q_cell.conf;
            r_a_left   <= clip(raw_l, lim_x);
            r_a_top    <= clip(raw_t, lim_y);
            r_a_right  <= clip(raw_r, lim_x);
            r_a_bottom <= clip(raw_b, lim_y);
        end
        if (b_take) begin
            r_o_cls    <= r_a_cls;
            r_o_conf   <= r_a_conf;
            r_o_left   <= r_a_left;
            r_o_top    <= r_a_top;
            r_o_width  <= {1'b0, r_a_right} - {1'b0, r_a_left} + DIM_W'(16);
            r_o_height <= {1'b0, r_a_bottom} - {1'b0, r_a_top} + DIM_W'(16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_adv) begin
                r_a_valid <= i_q_valid;
            end
            if (b_take) begin
                r_o_valid <= r_a_valid && box_ok;
            end
        end
    end

    assign o_valid          = r_o_valid;
    assign o_det_class      = r_o_cls;
    assign o_det_confidence = r_o_conf;
    assign o_box_left       = r_o_left;
    assign o_box_top        = r_o_top;
    assign o_box_width      = r_o_width;
    assign o_box_height     = r_o_height;

    // an emitted box always has area
    `GBD_ASSERT_IMP(a_box_area, i_clk, i_rst_n, r_o_valid, (r_o_width > DIM_W'(16)) && (r_o_height > DIM_W'(16)))
    // a stalled clip stage keeps its item
    `GBD_ASSERT_NXT(a_clip_hold, i_clk, i_rst_n, r_a_valid && !b_take, r_a_valid && $stable(r_a_left) && $stable(r_a_bottom))
    // clipped edges stay inside the image
    `GBD_ASSERT_IMP(a_clip_range, i_clk, i_rst_n, r_a_valid, (r_a_right <= lim_x) && (r_a_bottom <= lim_y))

endmodule

[design/grid_bbox_decode_filter.sv]
// top level of the grid box decoder and confidence filter
//
//  channel   handshake           payload
//  -------   -----------------   ----------------------------------------------
//  cell in   i_valid / o_ready   class, column, row, confidence, four offsets
//  box out   o_valid / i_ready   class, confidence, left, top, width, height
//  config    i_cfg_we            i_cfg_index, i_cfg_data (write only)
//
// one cell is taken every clock while the queue has room; the throughput is set
// by the combinational front (one 8x13 multiply per axis) feeding the queue
// a kept cell goes from the queue to the clip stage and then to the output register;
// dropped cells leave no trace
// reset is synchronous, active low, and loads the register reset values
// an output stall backs up the two back stages, then the queue; o_ready falls
// only once the queue is full
module grid_bbox_decode_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [gbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // grid cell input
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [gbd_pkg::CLS_W-1:0]     i_class_id,
    input  logic [gbd_pkg::GRID_W-1:0]    i_cell_col,
    input  logic [gbd_pkg::GRID_W-1:0]    i_cell_row,
    input  logic [gbd_pkg::CONF_W-1:0]    i_confidence,
    input  logic [gbd_pkg::OFS_W-1:0]     i_offset_x1,
    input  logic [gbd_pkg::OFS_W-1:0]     i_offset_y1,
    input  logic [gbd_pkg::OFS_W-1:0]     i_offset_x2,
    input  logic [gbd_pkg::OFS_W-1:0]     i_offset_y2,
    // detection output
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gbd_pkg::CLS_W-1:0]     o_det_class,
    output logic [gbd_pkg::CONF_W-1:0]    o_det_confidence,
    output logic [gbd_pkg::COORD_W-1:0]   o_box_left,
    output logic [gbd_pkg::COORD_W-1:0]   o_box_top,
    output logic [gbd_pkg::DIM_W-1:0]     o_box_width,
    output logic [gbd_pkg::DIM_W-1:0]     o_box_height
);
    import gbd_pkg::*;

    t_cfg  cfg;
    t_cell front_cell;
    t_cell q_cell;
    logic  q_space;
    logic  q_push;
    logic  q_valid;
    logic  q_pop;

    // register file; the user must keep it static while cells flow, the block does not enforce it
    gbd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // threshold test and reference point; only kept cells enter the queue
    gbd_front u_front (
        .i_valid      (i_valid),
        .i_space      (q_space),
        .i_class_id   (i_class_id),
        .i_cell_col   (i_cell_col),
        .i_cell_row   (i_cell_row),
        .i_confidence (i_confidence),
        .i_offset_x1  (i_offset_x1),
        .i_offset_y1  (i_offset_y1),
        .i_offset_x2  (i_offset_x2),
        .i_offset_y2  (i_offset_y2),
        .i_cfg        (cfg),
        .o_ready      (o_ready),
        .o_push       (q_push),
        .o_cell       (front_cell)
    );

    // decouples the input side from output stalls
    gbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cell  (front_cell),
        .i_pop   (q_pop),
        .o_space (q_space),
        .o_valid (q_valid),
        .o_cell  (q_cell)
    );

    // edge decode, clip, empty box drop, output register
    gbd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_q_valid        (q_valid),
        .i_q_cell         (q_cell),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_det_class      (o_det_class),
        .o_det_confidence (o_det_confidence),
        .o_box_left       (o_box_left),
        .o_box_top        (o_box_top),
        .o_box_width      (o_box_width),
        .o_box_height     (o_box_height)
    );

endmodule
